[hw/rtl/lgor_pkg.sv]
package lgor_pkg;

    // Group buffer geometry.
    localparam int GROUP_DEPTH = 32;
    localparam int IDX_W       = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int FILL_W      = $clog2(GROUP_DEPTH + 1);

    // Field widths.
    localparam int KIND_W = 3;
    localparam int CODE_W = 21;
    localparam int PAY_W  = 32;
    localparam int CAP_W  = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    // Op kinds.
    localparam logic [KIND_W-1:0] KIND_KEEP = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OVW  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DBG  = 3'd4;

    localparam logic [CODE_W-1:0] CODE_NEWLINE = 21'd10;

    // Scan passes over the group buffer.
    typedef logic [1:0] t_pass;
    localparam t_pass PASS_DEL = 2'd0;
    localparam t_pass PASS_INS = 2'd1;
    localparam t_pass PASS_DBG = 2'd2;

    // One buffered or emitted op.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [PAY_W-1:0]  payload;
    } t_op;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH_OP,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic scan_issue;
        logic flush_emit;
        logic finish;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_work;
        logic fill_zero;
        logic scan_last;
        logic pipe_vld;
        logic stall;
        logic item_flush;
        logic fin_ok;
    } t_dp_stat;

    // True when a buffered op of this kind is emitted by the given pass.
    function automatic logic kind_in_pass(input logic [KIND_W-1:0] kind, input t_pass pass);
        logic hit;
        unique case (pass)
            PASS_DEL: hit = (kind == KIND_DEL);
            PASS_INS: hit = (kind == KIND_INS) || (kind == KIND_OVW);
            PASS_DBG: hit = (kind == KIND_DBG);
            default:  hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

[hw/rtl/line_group_op_reorder_core.sv]
// Line group op reorder core.
// Input channel: i_in_valid / o_in_ready carry one edit op per beat
// (i_op_kind, i_char_code, i_op_payload, i_stream_end). Output channel:
// o_out_valid / i_out_ready carry one reordered op per beat, with o_run_last
// on the last beat caused by an input op and o_overflow_seen as the sticky
// group overflow flag. i_cfg_wr_en / i_cfg_wr_data write the output cap.
// Ops that are only buffered are taken back to back. A flush op
// (a non-debug keep or newline) or a stream end scans the group buffer three
// times through its single read port, one entry per cycle while the output
// does not stall; the input side stays closed until that op is finished.
// A scan hit waits in a hold stage until the next hit or the end of the op,
// then moves to the output register; a result thus passes the read stage,
// the hold stage and the output register in turn.
// When the receiver stalls, the scan pauses in place and resumes without loss.
// Reset clears the buffer fill, the emitted count, the overflow flag and all
// valid flags, and sets the cap to 65535; buffer contents need no clearing.
module line_group_op_reorder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lgor_pkg::KIND_W-1:0] i_op_kind,
    input  logic [lgor_pkg::CODE_W-1:0] i_char_code,
    input  logic [lgor_pkg::PAY_W-1:0]  i_op_payload,
    input  logic                        i_stream_end,
    input  logic                        i_cfg_wr_en,
    input  logic [lgor_pkg::CAP_W-1:0]  i_cfg_wr_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lgor_pkg::KIND_W-1:0] o_out_kind,
    output logic [lgor_pkg::CODE_W-1:0] o_out_code,
    output logic [lgor_pkg::PAY_W-1:0]  o_out_payload,
    output logic                        o_run_last,
    output logic                        o_overflow_seen
);

    lgor_pkg::t_ctl_cmd cmd;
    lgor_pkg::t_dp_stat stat;

    // Sequencer.
    lgor_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Buffer, counters and output stages.
    lgor_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_valid      (i_in_valid),
        .i_op_kind       (i_op_kind),
        .i_char_code     (i_char_code),
        .i_op_payload    (i_op_payload),
        .i_stream_end    (i_stream_end),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_kind      (o_out_kind),
        .o_out_code      (o_out_code),
        .o_out_payload   (o_out_payload),
        .o_run_last      (o_run_last),
        .o_overflow_seen (o_overflow_seen)
    );

    assign o_in_ready = cmd.take;

endmodule

[hw/rtl/lgor_ctrl.sv]
module lgor_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lgor_pkg::t_dp_stat  i_stat,
    output lgor_pkg::t_ctl_cmd  o_cmd
);

    lgor_pkg::t_state r_state;
    lgor_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgor_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lgor_pkg::ST_IDLE: begin
                if (i_in_valid && i_stat.in_work) begin
                    n_state = lgor_pkg::ST_SCAN;
                end
            end
            lgor_pkg::ST_SCAN: begin
                if (i_stat.fill_zero) begin
                    n_state = lgor_pkg::ST_DRAIN;
                end else if (!i_stat.stall && i_stat.scan_last) begin
                    n_state = lgor_pkg::ST_DRAIN;
                end
            end
            lgor_pkg::ST_DRAIN: begin
                if (!i_stat.pipe_vld || !i_stat.stall) begin
                    n_state = i_stat.item_flush ? lgor_pkg::ST_FLUSH_OP
                                                : lgor_pkg::ST_FINISH;
                end
            end
            lgor_pkg::ST_FLUSH_OP: begin
                if (!i_stat.stall) begin
                    n_state = lgor_pkg::ST_FINISH;
                end
            end
            lgor_pkg::ST_FINISH: begin
                if (i_stat.fin_ok) begin
                    n_state = lgor_pkg::ST_IDLE;
                end
            end
            default: n_state = lgor_pkg::ST_IDLE;
        endcase
    end

    // Commands decoded from the current state.
    always_comb begin
        o_cmd            = '0;
        o_cmd.take       = (r_state == lgor_pkg::ST_IDLE);
        o_cmd.scan_issue = (r_state == lgor_pkg::ST_SCAN) && !i_stat.fill_zero;
        o_cmd.flush_emit = (r_state == lgor_pkg::ST_FLUSH_OP);
        o_cmd.finish     = (r_state == lgor_pkg::ST_FINISH);
    end

endmodule

[hw/rtl/lgor_dp.sv]
module lgor_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lgor_pkg::t_ctl_cmd                   i_cmd,
    output lgor_pkg::t_dp_stat                   o_stat,
    input  logic                                 i_in_valid,
    input  logic [lgor_pkg::KIND_W-1:0]          i_op_kind,
    input  logic [lgor_pkg::CODE_W-1:0]          i_char_code,
    input  logic [lgor_pkg::PAY_W-1:0]           i_op_payload,
    input  logic                                 i_stream_end,
    input  logic                                 i_cfg_wr_en,
    input  logic [lgor_pkg::CAP_W-1:0]           i_cfg_wr_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [lgor_pkg::KIND_W-1:0]          o_out_kind,
    output logic [lgor_pkg::CODE_W-1:0]          o_out_code,
    output logic [lgor_pkg::PAY_W-1:0]           o_out_payload,
    output logic                                 o_run_last,
    output logic                                 o_overflow_seen
);

    // Group buffer.
    lgor_pkg::t_op r_mem [lgor_pkg::GROUP_DEPTH];

    // Stream state and configuration.
    logic [lgor_pkg::CAP_W-1:0]  r_cap;
    logic [lgor_pkg::FILL_W-1:0] r_fill;
    logic [lgor_pkg::CAP_W-1:0]  r_count;
    logic                        r_overflow;

    // Current item.
    lgor_pkg::t_op r_item;
    logic          r_item_flush;
    logic          r_item_end;

    // Scan position and read stage.
    logic [lgor_pkg::IDX_W-1:0] r_idx;
    lgor_pkg::t_pass            r_pass;
    logic                       r_rd_vld;
    lgor_pkg::t_pass            r_rd_pass;
    lgor_pkg::t_op              r_rd_data;

    // Hold stage: one result that waits until it is known whether it is the last.
    lgor_pkg::t_op r_hold;
    logic          r_hold_ovf;
    logic          r_hold_vld;

    // Output register.
    lgor_pkg::t_op r_out;
    logic          r_out_last;
    logic          r_out_ovf;
    logic          r_out_vld;

    logic          accept;
    logic          in_flush;
    logic          in_buf;
    logic          cap_ok;
    logic          scan_hit;
    logic          cand_vld;
    lgor_pkg::t_op cand;
    logic          out_free;
    logic          stall;
    logic          take_cand;
    logic          push_mid;
    logic          push_last;
    logic          rd_en;
    logic          fin_ok;

    // Classification of the incoming op.
    always_comb begin
        accept   = i_in_valid && i_cmd.take;
        in_flush = (i_op_kind != lgor_pkg::KIND_DBG) &&
                   ((i_op_kind == lgor_pkg::KIND_KEEP) || (i_char_code == lgor_pkg::CODE_NEWLINE));
        in_buf   = !in_flush && (i_op_kind >= lgor_pkg::KIND_DEL) &&
                   (i_op_kind <= lgor_pkg::KIND_DBG);
    end

    // Candidate result from the read stage or the flush op, and the stall rule.
    always_comb begin
        cap_ok    = (r_count < r_cap);
        scan_hit  = r_rd_vld && lgor_pkg::kind_in_pass(r_rd_data.kind, r_rd_pass);
        cand_vld  = (scan_hit || i_cmd.flush_emit) && cap_ok;
        cand      = scan_hit ? r_rd_data : r_item;
        out_free  = !r_out_vld || i_out_ready;
        stall     = cand_vld && r_hold_vld && !out_free;
        take_cand = cand_vld && !stall;
        push_mid  = cand_vld && r_hold_vld && out_free;
        push_last = i_cmd.finish && r_hold_vld && out_free;
        rd_en     = i_cmd.scan_issue && !stall;
        fin_ok    = !r_hold_vld || out_free;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lgor_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind    <= i_op_kind;
            r_item.code    <= i_char_code;
            r_item.payload <= i_op_payload;
            r_item_flush   <= in_flush;
            r_item_end     <= i_stream_end;
        end
    end

    // Buffer write on arrival.
    always_ff @(posedge i_clk) begin
        if (accept && in_buf && (r_fill < lgor_pkg::FILL_W'(lgor_pkg::GROUP_DEPTH))) begin
            r_mem[r_fill[lgor_pkg::IDX_W-1:0]] <= '{kind: i_op_kind, code: i_char_code,
                                                  payload: i_op_payload};
        end
    end

    // Buffer read, one entry per cycle; the data holds while the hold stage is blocked.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Fill count, emitted count and sticky overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            if (accept && in_buf) begin
                if (r_fill < lgor_pkg::FILL_W'(lgor_pkg::GROUP_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (take_cand) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.finish && fin_ok) begin
                r_fill <= '0;
                if (r_item_end) begin
                    r_count    <= '0;
                    r_overflow <= 1'b0;
                end
            end
        end
    end

    // Scan position: three passes over the filled entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pass <= lgor_pkg::PASS_DEL;
        end else if (accept) begin
            r_idx  <= '0;
            r_pass <= lgor_pkg::PASS_DEL;
        end else if (rd_en) begin
            if (r_idx == lgor_pkg::IDX_W'(r_fill - 1'b1)) begin
                r_idx  <= '0;
                r_pass <= r_pass + 1'b1;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Read stage valid and pass tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (!stall) begin
            r_rd_vld <= i_cmd.scan_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_pass <= r_pass;
        end
    end

    // Hold stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
        end else if (take_cand) begin
            r_hold_vld <= 1'b1;
        end else if (push_last) begin
            r_hold_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_cand) begin
            r_hold     <= cand;
            r_hold_ovf <= r_overflow;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push_mid || push_last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_mid || push_last) begin
            r_out      <= r_hold;
            r_out_ovf  <= r_hold_ovf;
            r_out_last <= push_last;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.in_work    = in_flush || i_stream_end;
        o_stat.fill_zero  = (r_fill == '0);
        o_stat.scan_last  = (r_pass == lgor_pkg::PASS_DBG) &&
                            (r_idx == lgor_pkg::IDX_W'(r_fill - 1'b1));
        o_stat.pipe_vld   = r_rd_vld;
        o_stat.stall      = stall;
        o_stat.item_flush = r_item_flush;
        o_stat.fin_ok     = fin_ok;
    end

    assign o_out_valid     = r_out_vld;
    assign o_out_kind      = r_out.kind;
    assign o_out_code      = r_out.code;
    assign o_out_payload   = r_out.payload;
    assign o_run_last      = r_out_last;
    assign o_overflow_seen = r_out_ovf;

endmodule

[hw/rtl/lgor_checker.sv]
module lgor_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [lgor_pkg::KIND_W-1:0] i_op_kind,
    input logic [lgor_pkg::CODE_W-1:0] i_char_code,
    input logic                        i_stream_end,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [lgor_pkg::KIND_W-1:0] o_out_kind,
    input logic [lgor_pkg::CODE_W-1:0] o_out_code,
    input logic [lgor_pkg::PAY_W-1:0]  o_out_payload,
    input logic                        o_run_last,
    input logic                        o_overflow_seen
);

    // An output beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat withdrawn before it was taken");

    // A stalled output beat keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_kind) && $stable(o_out_code) &&
            $stable(o_out_payload) && $stable(o_run_last) && $stable(o_overflow_seen))
        else $error("output beat changed while stalled");

    // An op that is neither a keep, a newline nor a stream end leaves the input side open for the next beat.
    a_buffer_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_stream_end &&
        i_op_kind != lgor_pkg::KIND_KEEP && i_char_code != lgor_pkg::CODE_NEWLINE
        |=> o_in_ready)
        else $error("input side closed after a buffered op");

    // A keep op or a stream end starts a flush, which closes the input side.
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_stream_end || i_op_kind == lgor_pkg::KIND_KEEP)
        |=> !o_in_ready)
        else $error("input side open during a flush");

endmodule

bind line_group_op_reorder_core lgor_checker u_lgor_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_op_kind       (i_op_kind),
    .i_char_code     (i_char_code),
    .i_stream_end    (i_stream_end),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_kind      (o_out_kind),
    .o_out_code      (o_out_code),
    .o_out_payload   (o_out_payload),
    .o_run_last      (o_run_last),
    .o_overflow_seen (o_overflow_seen)
);
